// File: hw/rtl/tail_light_frame_renderer_unit_assert.svh
// Assertion macros shared by the tail light renderer modules.
`ifndef TAIL_LIGHT_FRAME_RENDERER_UNIT_ASSERT_SVH
`define TAIL_LIGHT_FRAME_RENDERER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TLFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tlfr assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is asserted.
`define TLFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tlfr assertion failed: next-cycle check");

`endif

// File: hw/rtl/tlfr_pkg.sv
// Shared types and constants of the tail light frame renderer.
package tlfr_pkg;

    localparam int LED_COUNT_DEF = 24;

    localparam int LED_IDX_W  = 6;
    localparam int COL_W      = 8;
    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_COMBINED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_CNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_HALF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REARM      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_HOLD  = 3'd5;

    // register reset values
    localparam logic [3:0]  RST_PULSE_CNT  = 4'd3;
    localparam logic [9:0]  RST_PULSE_HALF = 10'd60;
    localparam logic [15:0] RST_REARM      = 16'd1500;
    localparam logic [15:0] RST_SWEEP      = 16'd300;
    localparam logic [15:0] RST_TURN_HOLD  = 16'd700;

    // brake lamp modes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_RUN   = 2'd1;
    localparam logic [1:0] MODE_PULSE = 2'd2;
    localparam logic [1:0] MODE_HOLD  = 2'd3;

    // colour levels
    localparam logic [COL_W-1:0] LVL_OFF  = 8'd0;
    localparam logic [COL_W-1:0] LVL_DIM  = 8'd48;
    localparam logic [COL_W-1:0] LVL_AMB  = 8'd80;
    localparam logic [COL_W-1:0] LVL_FULL = 8'd255;

    // shared divider: 32-bit time times a 6-bit zone factor over a 16-bit divisor
    localparam int TRN_M1_W = 6;
    localparam int DIV_NW   = TIME_W + TRN_M1_W;
    localparam int DIV_DW   = 16;

    localparam logic DIV_SEL_PHASE = 1'b0;
    localparam logic DIV_SEL_SWEEP = 1'b1;

    typedef struct packed {
        logic load_in;
        logic update;
        logic div_start;
        logic div_sel;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic last_loaded;
    } t_sts;

endpackage

// File: hw/rtl/tlfr_if.sv
// Channel interfaces of the tail light frame renderer.
interface tlfr_in_if;
    logic                        valid;
    logic                        ready;
    logic [tlfr_pkg::TIME_W-1:0] now_ms;
    logic                        run_on;
    logic                        run_full;
    logic                        brake_on;
    logic                        turn_on;
    logic                        reverse_on;
    logic                        fog_on;

    modport source (output valid, now_ms, run_on, run_full, brake_on, turn_on,
                    reverse_on, fog_on, input ready);
    modport sink   (input valid, now_ms, run_on, run_full, brake_on, turn_on,
                    reverse_on, fog_on, output ready);
endinterface

interface tlfr_out_if;
    logic                           valid;
    logic                           ready;
    logic [tlfr_pkg::LED_IDX_W-1:0] led_index;
    logic [tlfr_pkg::COL_W-1:0]     red;
    logic [tlfr_pkg::COL_W-1:0]     green;
    logic [tlfr_pkg::COL_W-1:0]     blue;
    logic                           last;

    modport source (output valid, led_index, red, green, blue, last, input ready);
    modport sink   (input valid, led_index, red, green, blue, last, output ready);
endinterface

interface tlfr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [tlfr_pkg::CFG_IDX_W-1:0]  index;
    logic [tlfr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/tlfr_div.sv
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module tlfr_div #(
    parameter int NW = tlfr_pkg::DIV_NW,
    parameter int DW = tlfr_pkg::DIV_DW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_busy,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);
    localparam int CNT_W = $clog2(NW);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW - 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NW-1:0]    r_quo;
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;

    logic [DW:0]      rem_sh;
    logic [DW:0]      diff;
    logic             ge;
    logic [DW-1:0]    n_rem;
    logic [NW-1:0]    n_quo;

    always_comb begin
        rem_sh = {r_rem, r_quo[NW-1]};
        diff   = rem_sh - {1'b0, r_den};
        ge     = (rem_sh >= {1'b0, r_den});
        n_rem  = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        n_quo  = {r_quo[NW-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule

// File: hw/rtl/tlfr_ctrl.sv
// Frame sequencer of the tail light renderer.
`include "tail_light_frame_renderer_unit_assert.svh"

module tlfr_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output tlfr_pkg::t_cmd o_cmd,
    input  tlfr_pkg::t_sts i_sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_UPD  = 3'd1;
    localparam logic [2:0] S_PST  = 3'd2;
    localparam logic [2:0] S_PW   = 3'd3;
    localparam logic [2:0] S_SST  = 3'd4;
    localparam logic [2:0] S_SW   = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = S_PST;
            end
            S_PST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = tlfr_pkg::DIV_SEL_PHASE;
                n_state         = S_PW;
            end
            S_PW: begin
                o_cmd.div_sel = tlfr_pkg::DIV_SEL_PHASE;
                if (i_sts.div_done) begin
                    n_state = S_SST;
                end
            end
            S_SST: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = tlfr_pkg::DIV_SEL_SWEEP;
                n_state         = S_SW;
            end
            S_SW: begin
                o_cmd.div_sel = tlfr_pkg::DIV_SEL_SWEEP;
                if (i_sts.div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                if (i_sts.last_loaded) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    `TLFR_ASSERT_NEXT(a_last_ends_frame, i_clk, i_rst_n, i_sts.last_loaded, r_state == S_IDLE)
endmodule

// File: hw/rtl/tlfr_dp.sv
// Datapath of the tail light renderer: registers, lamp state, divider, pixel output.
`include "tail_light_frame_renderer_unit_assert.svh"

module tlfr_dp #(
    parameter int LED_COUNT = tlfr_pkg::LED_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  tlfr_pkg::t_cmd                      i_cmd,
    output tlfr_pkg::t_sts                      o_sts,
    input  logic                                i_cfg_valid,
    input  logic [tlfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tlfr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [tlfr_pkg::TIME_W-1:0]         i_now_ms,
    input  logic                                i_run_on,
    input  logic                                i_run_full,
    input  logic                                i_brake_on,
    input  logic                                i_turn_on,
    input  logic                                i_reverse_on,
    input  logic                                i_fog_on,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [tlfr_pkg::LED_IDX_W-1:0]      o_led_index,
    output logic [tlfr_pkg::COL_W-1:0]          o_red,
    output logic [tlfr_pkg::COL_W-1:0]          o_green,
    output logic [tlfr_pkg::COL_W-1:0]          o_blue,
    output logic                                o_last
);
    localparam int TW = tlfr_pkg::TIME_W;
    localparam int NW = tlfr_pkg::DIV_NW;
    localparam int DW = tlfr_pkg::DIV_DW;
    localparam int IW = tlfr_pkg::LED_IDX_W;
    localparam int CW = tlfr_pkg::COL_W;

    // zone bounds, one bit wider than the LED index
    localparam logic [IW:0] C_REV_LEN   = (IW+1)'(LED_COUNT / 3);
    localparam logic [IW:0] C_FOG_START = (IW+1)'(LED_COUNT / 3);
    localparam logic [IW:0] C_FOG_END   = (IW+1)'(2 * (LED_COUNT / 3));
    localparam logic [IW:0] C_TRN_START = (IW+1)'(2 * LED_COUNT / 3);
    localparam logic [IW:0] C_TRN_LEN   = (IW+1)'(LED_COUNT - 2 * LED_COUNT / 3);
    localparam logic [tlfr_pkg::TRN_M1_W-1:0] C_TRN_M1 =
        tlfr_pkg::TRN_M1_W'(LED_COUNT - 2 * LED_COUNT / 3 - 1);
    localparam logic [IW-1:0] C_LAST_IDX = IW'(LED_COUNT - 1);

    // configuration registers
    logic          r_combined;
    logic [3:0]    r_pulse_cnt;
    logic [9:0]    r_pulse_half;
    logic [15:0]   r_rearm;
    logic [15:0]   r_sweep;
    logic [15:0]   r_hold;

    // latched frame inputs
    logic [TW-1:0] r_now;
    logic          r_run;
    logic          r_full;
    logic          r_brake;
    logic          r_turn;
    logic          r_rev;
    logic          r_fog;

    // lamp state
    logic [1:0]    r_mode;
    logic [TW-1:0] r_brake_start;
    logic [TW-1:0] r_brake_rel;
    logic          r_turn_was;
    logic [TW-1:0] r_turn_start;
    logic [TW-1:0] r_turn_seen;

    // per-frame results
    logic          r_engaged;
    logic          r_phase_odd;
    logic [IW:0]   r_lit;

    // output stage
    logic          r_out_valid;
    logic [IW-1:0] r_idx;
    logic [IW-1:0] r_o_idx;
    logic [CW-1:0] r_o_red;
    logic [CW-1:0] r_o_green;
    logic [CW-1:0] r_o_blue;
    logic          r_o_last;

    // update logic
    logic          run_eff;
    logic          brake_eff;
    logic [TW-1:0] dt_rel;
    logic [TW-1:0] dt_start;
    logic [TW-1:0] dt_turn;
    logic [TW-1:0] dt_seen;
    logic [13:0]   pulse_prod;
    logic [14:0]   pulse_time;
    logic [1:0]    n_mode;
    logic [TW-1:0] n_brake_start;
    logic [TW-1:0] n_brake_rel;

    // divider hookup
    logic [NW-1:0] div_num;
    logic [DW-1:0] div_den;
    logic          div_busy;
    logic          div_done;
    logic [NW-1:0] div_quo;
    logic [IW:0]   n_lit;

    // pixel logic
    logic [IW:0]   idx_w;
    logic [CW-1:0] base_r;
    logic [CW-1:0] px_r;
    logic [CW-1:0] px_g;
    logic [CW-1:0] px_b;
    logic          px_load;

    // configuration writes; unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_combined   <= 1'b0;
            r_pulse_cnt  <= tlfr_pkg::RST_PULSE_CNT;
            r_pulse_half <= tlfr_pkg::RST_PULSE_HALF;
            r_rearm      <= tlfr_pkg::RST_REARM;
            r_sweep      <= tlfr_pkg::RST_SWEEP;
            r_hold       <= tlfr_pkg::RST_TURN_HOLD;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlfr_pkg::REG_COMBINED:   r_combined   <= i_cfg_data[0];
                tlfr_pkg::REG_PULSE_CNT:  r_pulse_cnt  <= i_cfg_data[3:0];
                tlfr_pkg::REG_PULSE_HALF: r_pulse_half <= i_cfg_data[9:0];
                tlfr_pkg::REG_REARM:      r_rearm      <= i_cfg_data;
                tlfr_pkg::REG_SWEEP:      r_sweep      <= i_cfg_data;
                tlfr_pkg::REG_TURN_HOLD:  r_hold       <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_now   <= i_now_ms;
            r_run   <= i_run_on;
            r_full  <= i_run_full;
            r_brake <= i_brake_on;
            r_turn  <= i_turn_on;
            r_rev   <= i_reverse_on;
            r_fog   <= i_fog_on;
        end
    end

    always_comb begin
        run_eff       = r_combined ? (r_run & ~r_full) : r_run;
        brake_eff     = r_combined ? r_full : r_brake;
        dt_rel        = r_now - r_brake_rel;
        dt_start      = r_now - r_brake_start;
        dt_turn       = r_now - r_turn_start;
        dt_seen       = r_now - r_turn_seen;
        pulse_prod    = 14'(r_pulse_cnt) * 14'(r_pulse_half);
        pulse_time    = {pulse_prod, 1'b0};
        n_mode        = r_mode;
        n_brake_start = r_brake_start;
        n_brake_rel   = r_brake_rel;
        case (r_mode)
            tlfr_pkg::MODE_IDLE, tlfr_pkg::MODE_RUN: begin
                if (brake_eff) begin
                    if (dt_rel >= TW'(r_rearm)) begin
                        n_mode        = tlfr_pkg::MODE_PULSE;
                        n_brake_start = r_now;
                    end else begin
                        n_mode = tlfr_pkg::MODE_HOLD;
                    end
                end else begin
                    n_mode = run_eff ? tlfr_pkg::MODE_RUN : tlfr_pkg::MODE_IDLE;
                end
            end
            tlfr_pkg::MODE_PULSE: begin
                if (!brake_eff) begin
                    n_brake_rel = r_now;
                    n_mode      = run_eff ? tlfr_pkg::MODE_RUN : tlfr_pkg::MODE_IDLE;
                end else if (dt_start >= TW'(pulse_time)) begin
                    n_mode = tlfr_pkg::MODE_HOLD;
                end
            end
            default: begin
                if (!brake_eff) begin
                    n_brake_rel = r_now;
                    n_mode      = run_eff ? tlfr_pkg::MODE_RUN : tlfr_pkg::MODE_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= tlfr_pkg::MODE_IDLE;
            r_brake_start <= '0;
            r_brake_rel   <= TW'(0) - TW'(tlfr_pkg::RST_REARM);
            r_turn_was    <= 1'b0;
            r_turn_start  <= '0;
            r_turn_seen   <= TW'(0) - TW'(tlfr_pkg::RST_TURN_HOLD);
            r_engaged     <= 1'b0;
        end else if (i_cmd.update) begin
            r_mode        <= n_mode;
            r_brake_start <= n_brake_start;
            r_brake_rel   <= n_brake_rel;
            r_turn_was    <= r_turn;
            if (r_turn && !r_turn_was) begin
                r_turn_start <= r_now;
            end
            if (r_turn) begin
                r_turn_seen <= r_now;
            end
            r_engaged <= r_turn | (dt_seen < TW'(r_hold));
        end
    end

    // flash phase first, then sweep length; both use the same divider
    always_comb begin
        if (i_cmd.div_sel == tlfr_pkg::DIV_SEL_SWEEP) begin
            div_num = NW'(dt_turn) * NW'(C_TRN_M1);
            div_den = r_sweep;
        end else begin
            div_num = NW'(dt_start);
            div_den = DW'(r_pulse_half);
        end
    end

    tlfr_div #(
        .NW (NW),
        .DW (DW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_comb begin
        if (!r_turn) begin
            n_lit = '0;
        end else if (r_sweep == '0) begin
            n_lit = C_TRN_LEN;
        end else if (div_quo >= NW'(C_TRN_LEN)) begin
            n_lit = C_TRN_LEN;
        end else begin
            n_lit = div_quo[IW:0] + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_odd <= 1'b0;
            r_lit       <= '0;
        end else if (div_done) begin
            if (i_cmd.div_sel == tlfr_pkg::DIV_SEL_SWEEP) begin
                r_lit <= n_lit;
            end else begin
                // a zero half period keeps the phase even
                r_phase_odd <= (r_pulse_half != '0) & div_quo[0];
            end
        end
    end

    // layer base, fog, reverse and turn zone for the current LED
    always_comb begin
        idx_w = {1'b0, r_idx};
        case (r_mode)
            tlfr_pkg::MODE_RUN:   base_r = tlfr_pkg::LVL_DIM;
            tlfr_pkg::MODE_HOLD:  base_r = tlfr_pkg::LVL_FULL;
            tlfr_pkg::MODE_PULSE: base_r = r_phase_odd ? tlfr_pkg::LVL_DIM
                                                       : tlfr_pkg::LVL_FULL;
            default:              base_r = tlfr_pkg::LVL_OFF;
        endcase
        px_r = base_r;
        px_g = tlfr_pkg::LVL_OFF;
        px_b = tlfr_pkg::LVL_OFF;
        if (r_fog && idx_w >= C_FOG_START && idx_w < C_FOG_END) begin
            px_r = tlfr_pkg::LVL_FULL;
            px_g = tlfr_pkg::LVL_OFF;
            px_b = tlfr_pkg::LVL_OFF;
        end
        if (r_rev && idx_w < C_REV_LEN) begin
            px_r = tlfr_pkg::LVL_FULL;
            px_g = tlfr_pkg::LVL_FULL;
            px_b = tlfr_pkg::LVL_FULL;
        end
        if (r_engaged && idx_w >= C_TRN_START) begin
            px_r = tlfr_pkg::LVL_OFF;
            px_g = tlfr_pkg::LVL_OFF;
            px_b = tlfr_pkg::LVL_OFF;
            if (r_turn && idx_w < C_TRN_START + r_lit) begin
                px_r = tlfr_pkg::LVL_FULL;
                px_g = tlfr_pkg::LVL_AMB;
                px_b = tlfr_pkg::LVL_OFF;
            end
        end
    end

    assign px_load = i_cmd.emit & (~r_out_valid | i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            if (px_load) begin
                r_out_valid <= 1'b1;
                r_idx       <= (r_idx == C_LAST_IDX) ? '0 : r_idx + 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (px_load) begin
            r_o_idx   <= r_idx;
            r_o_red   <= px_r;
            r_o_green <= px_g;
            r_o_blue  <= px_b;
            r_o_last  <= (r_idx == C_LAST_IDX);
        end
    end

    assign o_sts.div_done    = div_done;
    assign o_sts.last_loaded = px_load & (r_idx == C_LAST_IDX);

    assign o_out_valid = r_out_valid;
    assign o_led_index = r_o_idx;
    assign o_red       = r_o_red;
    assign o_green     = r_o_green;
    assign o_blue      = r_o_blue;
    assign o_last      = r_o_last;

    `TLFR_ASSERT_NOW(a_div_start_idle, i_clk, i_rst_n, i_cmd.div_start, !div_busy)
    `TLFR_ASSERT_NOW(a_lit_in_zone, i_clk, i_rst_n, 1'b1, r_lit <= C_TRN_LEN)
    `TLFR_ASSERT_NOW(a_frame_starts_at_zero, i_clk, i_rst_n, i_cmd.load_in, r_idx == '0)
endmodule

// File: hw/rtl/tail_light_frame_renderer_unit.sv
// Top level of the tail light frame renderer.
//
//  channel    | direction | payload                                        | handshake
//  -----------+-----------+------------------------------------------------+------------
//  i_cfg_ch   | in        | index (3 b), data (16 b)                       | valid/ready
//  i_in_ch    | in        | now_ms, run_on, run_full, brake_on, turn_on,   | valid/ready
//             |           | reverse_on, fog_on                             |
//  o_out_ch   | out       | led_index, red, green, blue, last              | valid/ready
//
// One frame transaction in gives LED_COUNT LED transactions out, LED 0 first.
// A frame runs in these steps: latch the inputs, advance the lamp state, then two
// passes of the one-bit-per-cycle divider (38 quotient bits each, flash phase and
// sweep length), then one LED per cycle while the output is not stalled.
// The next frame is taken once the last LED of the current one sits in the output
// register. Output stalls hold the LED in its register and freeze the LED counter.
// Reset is synchronous, active low; the configuration channel is always ready.
module tail_light_frame_renderer_unit #(
    parameter int LED_COUNT = tlfr_pkg::LED_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tlfr_cfg_if.sink    i_cfg_ch,
    tlfr_in_if.sink     i_in_ch,
    tlfr_out_if.source  o_out_ch
);
    tlfr_pkg::t_cmd cmd;
    tlfr_pkg::t_sts sts;
    logic           in_ready;

    // register writes never stall
    assign i_cfg_ch.ready = 1'b1;
    assign i_in_ch.ready  = in_ready;

    tlfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_ch.valid),
        .o_in_ready (in_ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    tlfr_dp #(
        .LED_COUNT (LED_COUNT)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_valid  (i_cfg_ch.valid),
        .i_cfg_index  (i_cfg_ch.index),
        .i_cfg_data   (i_cfg_ch.data),
        .i_now_ms     (i_in_ch.now_ms),
        .i_run_on     (i_in_ch.run_on),
        .i_run_full   (i_in_ch.run_full),
        .i_brake_on   (i_in_ch.brake_on),
        .i_turn_on    (i_in_ch.turn_on),
        .i_reverse_on (i_in_ch.reverse_on),
        .i_fog_on     (i_in_ch.fog_on),
        .o_out_valid  (o_out_ch.valid),
        .i_out_ready  (o_out_ch.ready),
        .o_led_index  (o_out_ch.led_index),
        .o_red        (o_out_ch.red),
        .o_green      (o_out_ch.green),
        .o_blue       (o_out_ch.blue),
        .o_last       (o_out_ch.last)
    );
endmodule

// File: tb/tail_light_frame_renderer_unit_checker.sv
// Frame predictor and LED scoreboard for the tail light frame renderer.
`timescale 1ns / 1ps

module tail_light_frame_renderer_unit_checker #(
    parameter int LED_COUNT = tlfr_pkg::LED_COUNT_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tlfr_cfg_if  i_cfg_ch,
    tlfr_in_if   i_in_ch,
    tlfr_out_if  i_out_ch,
    output int   o_fail_count,
    output int   o_pending
);
    localparam int REV_LEN   = LED_COUNT / 3;
    localparam int FOG_START = LED_COUNT / 3;
    localparam int FOG_END   = FOG_START + LED_COUNT / 3;
    localparam int TRN_START = 2 * LED_COUNT / 3;
    localparam int TRN_LEN   = LED_COUNT - TRN_START;
    localparam int TW        = tlfr_pkg::TIME_W;

    typedef struct packed {
        logic [tlfr_pkg::LED_IDX_W-1:0] led_index;
        logic [tlfr_pkg::COL_W-1:0]     red;
        logic [tlfr_pkg::COL_W-1:0]     green;
        logic [tlfr_pkg::COL_W-1:0]     blue;
        logic                           last;
    } t_led;

    t_led expected_leds[$];
    int   fail_count = 0;

    // register copies
    logic        combined;
    logic [3:0]  flash_count;
    logic [9:0]  flash_half;
    logic [15:0] rearm;
    logic [15:0] sweep;
    logic [15:0] turn_hold;

    // lamp state
    logic [1:0]    lamp_mode;
    logic [TW-1:0] brake_start;
    logic [TW-1:0] brake_release;
    logic          turn_was_on;
    logic [TW-1:0] turn_start;
    logic [TW-1:0] turn_seen;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: LED mismatch: %s", $time, msg);
        fail_count++;
    endtask

    task automatic reset_lamp_model();
        combined      = 1'b0;
        flash_count   = tlfr_pkg::RST_PULSE_CNT;
        flash_half    = tlfr_pkg::RST_PULSE_HALF;
        rearm         = tlfr_pkg::RST_REARM;
        sweep         = tlfr_pkg::RST_SWEEP;
        turn_hold     = tlfr_pkg::RST_TURN_HOLD;
        lamp_mode     = tlfr_pkg::MODE_IDLE;
        brake_start   = '0;
        brake_release = 32'd0 - 32'(tlfr_pkg::RST_REARM);
        turn_was_on   = 1'b0;
        turn_start    = '0;
        turn_seen     = 32'd0 - 32'(tlfr_pkg::RST_TURN_HOLD);
    endtask

    // Stored times are left alone: only the register copy changes.
    task automatic apply_setting(input logic [tlfr_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [tlfr_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            tlfr_pkg::REG_COMBINED:   combined    = data[0];
            tlfr_pkg::REG_PULSE_CNT:  flash_count = data[3:0];
            tlfr_pkg::REG_PULSE_HALF: flash_half  = data[9:0];
            tlfr_pkg::REG_REARM:      rearm       = data;
            tlfr_pkg::REG_SWEEP:      sweep       = data;
            tlfr_pkg::REG_TURN_HOLD:  turn_hold   = data;
            default: ;
        endcase
    endtask

    task automatic render_frame(input logic [TW-1:0] now, input logic run_in,
                                input logic full_in, input logic brake_in,
                                input logic turn, input logic rev, input logic fog);
        logic                       run;
        logic                       brake;
        logic                       engaged;
        logic [TW-1:0]              dt;
        logic [TW-1:0]              phase;
        logic [63:0]                lit_wide;
        int                         lit;
        logic [tlfr_pkg::COL_W-1:0] base_r;
        t_led                       led;

        if (combined) begin
            run   = run_in && !full_in;
            brake = full_in;
        end else begin
            run   = run_in;
            brake = brake_in;
        end

        // advance the brake machine
        case (lamp_mode)
            tlfr_pkg::MODE_IDLE, tlfr_pkg::MODE_RUN: begin
                dt = now - brake_release;
                if (brake) begin
                    if (dt >= 32'(rearm)) begin
                        lamp_mode   = tlfr_pkg::MODE_PULSE;
                        brake_start = now;
                    end else begin
                        lamp_mode = tlfr_pkg::MODE_HOLD;
                    end
                end else begin
                    lamp_mode = run ? tlfr_pkg::MODE_RUN : tlfr_pkg::MODE_IDLE;
                end
            end
            tlfr_pkg::MODE_PULSE: begin
                dt = now - brake_start;
                if (!brake) begin
                    brake_release = now;
                    lamp_mode     = run ? tlfr_pkg::MODE_RUN : tlfr_pkg::MODE_IDLE;
                end else if (dt >= 32'(flash_count) * 32'(flash_half) * 32'd2) begin
                    lamp_mode = tlfr_pkg::MODE_HOLD;
                end
            end
            default: begin
                if (!brake) begin
                    brake_release = now;
                    lamp_mode     = run ? tlfr_pkg::MODE_RUN : tlfr_pkg::MODE_IDLE;
                end
            end
        endcase

        if (turn && !turn_was_on)
            turn_start = now;
        if (turn)
            turn_seen = now;
        turn_was_on = turn;

        base_r = tlfr_pkg::LVL_OFF;
        case (lamp_mode)
            tlfr_pkg::MODE_RUN:  base_r = tlfr_pkg::LVL_DIM;
            tlfr_pkg::MODE_HOLD: base_r = tlfr_pkg::LVL_FULL;
            tlfr_pkg::MODE_PULSE: begin
                phase = '0;
                if (flash_half != 0)
                    phase = (now - brake_start) / 32'(flash_half);
                base_r = phase[0] ? tlfr_pkg::LVL_DIM : tlfr_pkg::LVL_FULL;
            end
            default: ;
        endcase

        dt      = now - turn_seen;
        engaged = turn || (dt < 32'(turn_hold));
        lit     = 0;
        if (turn) begin
            if (sweep == 0) begin
                lit = TRN_LEN;
            end else begin
                // widen before the product: the sweep count must not wrap
                dt       = now - turn_start;
                lit_wide = 64'd1 + (64'(dt) * 64'(TRN_LEN - 1)) / 64'(sweep);
                lit      = (lit_wide > 64'(TRN_LEN)) ? TRN_LEN : int'(lit_wide);
            end
        end

        for (int i = 0; i < LED_COUNT; i++) begin
            led.led_index = tlfr_pkg::LED_IDX_W'(i);
            led.red       = base_r;
            led.green     = tlfr_pkg::LVL_OFF;
            led.blue      = tlfr_pkg::LVL_OFF;
            led.last      = (i == LED_COUNT - 1);
            if (fog && i >= FOG_START && i < FOG_END) begin
                led.red   = tlfr_pkg::LVL_FULL;
                led.green = tlfr_pkg::LVL_OFF;
                led.blue  = tlfr_pkg::LVL_OFF;
            end
            if (rev && i < REV_LEN) begin
                led.red   = tlfr_pkg::LVL_FULL;
                led.green = tlfr_pkg::LVL_FULL;
                led.blue  = tlfr_pkg::LVL_FULL;
            end
            if (engaged && i >= TRN_START) begin
                led.red   = tlfr_pkg::LVL_OFF;
                led.green = tlfr_pkg::LVL_OFF;
                led.blue  = tlfr_pkg::LVL_OFF;
                if (turn && i < TRN_START + lit) begin
                    led.red   = tlfr_pkg::LVL_FULL;
                    led.green = tlfr_pkg::LVL_AMB;
                end
            end
            expected_leds.push_back(led);
        end
    endtask

    task automatic check_led();
        t_led want;

        if (expected_leds.size() == 0) begin
            report_mismatch($sformatf("LED %0d arrived with no frame pending",
                                      i_out_ch.led_index));
        end else begin
            want = expected_leds.pop_front();
            if (i_out_ch.led_index !== want.led_index)
                report_mismatch($sformatf("led_index got %0d want %0d",
                                          i_out_ch.led_index, want.led_index));
            if (i_out_ch.red !== want.red)
                report_mismatch($sformatf("LED %0d red got %0d want %0d",
                                          want.led_index, i_out_ch.red, want.red));
            if (i_out_ch.green !== want.green)
                report_mismatch($sformatf("LED %0d green got %0d want %0d",
                                          want.led_index, i_out_ch.green, want.green));
            if (i_out_ch.blue !== want.blue)
                report_mismatch($sformatf("LED %0d blue got %0d want %0d",
                                          want.led_index, i_out_ch.blue, want.blue));
            if (i_out_ch.last !== want.last)
                report_mismatch($sformatf("LED %0d last got %0b want %0b",
                                          want.led_index, i_out_ch.last, want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_lamp_model();
            expected_leds.delete();
        end else begin
            if (i_cfg_ch.valid && i_cfg_ch.ready)
                apply_setting(i_cfg_ch.index, i_cfg_ch.data);
            if (i_in_ch.valid && i_in_ch.ready)
                render_frame(i_in_ch.now_ms, i_in_ch.run_on, i_in_ch.run_full,
                             i_in_ch.brake_on, i_in_ch.turn_on, i_in_ch.reverse_on,
                             i_in_ch.fog_on);
            if (i_out_ch.valid && i_out_ch.ready)
                check_led();
        end
        o_pending    <= expected_leds.size();
        o_fail_count <= fail_count;
    end

endmodule

// File: tb/tail_light_frame_renderer_unit_tb.sv
// Stimulus, back-pressure and verdict for the tail light frame renderer.
`timescale 1ns / 1ps

module tail_light_frame_renderer_unit_tb;
    localparam int LED_COUNT      = tlfr_pkg::LED_COUNT_DEF;
    localparam int TW             = tlfr_pkg::TIME_W;
    localparam int IXW            = tlfr_pkg::CFG_IDX_W;
    localparam int DTW            = tlfr_pkg::CFG_DATA_W;
    localparam int CLK_PERIOD     = 10;
    localparam int FRAME_LATENCY  = 150;   // cycles of settling after the LED stream drains
    localparam int WATCHDOG_LIMIT = 10000; // cycles with no transaction on any channel
    localparam int SEGMENTS       = 8;
    localparam int SEGMENT_TICKS  = 22;

    // indexes beyond the register file; the block must drop these writes
    localparam logic [IXW-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [IXW-1:0] REG_SPARE_HI = 3'd7;

    logic clk = 1'b0;
    logic rst_n;
    int   sender_idle_pct;
    int   receiver_idle_pct;
    int   fail_count;
    int   pending;
    int   quiet_cycles = 0;

    tlfr_cfg_if cfg_ch ();
    tlfr_in_if  frame_ch ();
    tlfr_out_if led_ch ();

    tail_light_frame_renderer_unit #(
        .LED_COUNT(LED_COUNT)
    ) u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_cfg_ch (cfg_ch),
        .i_in_ch  (frame_ch),
        .o_out_ch (led_ch)
    );

    tail_light_frame_renderer_unit_checker #(
        .LED_COUNT(LED_COUNT)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_ch     (cfg_ch),
        .i_in_ch      (frame_ch),
        .i_out_ch     (led_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Stall the LED stream at random; a zero percentage keeps ready high.
    always @(posedge clk) begin
        led_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Count cycles with no transaction anywhere and give up once the count gets absurd.
    always @(posedge clk) begin
        if ((cfg_ch.valid && cfg_ch.ready) || (frame_ch.valid && frame_ch.ready) ||
            (led_ch.valid && led_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tail_light_frame_renderer_unit test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one frame tick and hold it until the block takes it. Valid stays high on
    // return, so a following tick with no gap keeps the channel busy without a bubble.
    task automatic send_tick(input logic [TW-1:0] now, input logic run,
                             input logic full, input logic brake, input logic turn,
                             input logic rev, input logic fog);
        while ($urandom_range(99) < sender_idle_pct) begin
            frame_ch.valid <= 1'b0;
            @(posedge clk);
        end
        frame_ch.valid      <= 1'b1;
        frame_ch.now_ms     <= now;
        frame_ch.run_on     <= run;
        frame_ch.run_full   <= full;
        frame_ch.brake_on   <= brake;
        frame_ch.turn_on    <= turn;
        frame_ch.reverse_on <= rev;
        frame_ch.fog_on     <= fog;
        do @(posedge clk); while (!(frame_ch.valid && frame_ch.ready));
    endtask

    // Drop valid, let every predicted LED drain, then give the pipeline time to settle.
    // The first edge is always consumed so a frame taken at this edge is counted.
    task automatic wait_drained();
        frame_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (FRAME_LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IXW-1:0] idx, input logic [DTW-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
    endtask

    // Write every register back to back, sometimes followed by a stray index.
    task automatic program_all(input logic [15:0] combined, input logic [15:0] pcount,
                               input logic [15:0] phalf, input logic [15:0] rearm,
                               input logic [15:0] sweep, input logic [15:0] hold);
        write_reg(tlfr_pkg::REG_COMBINED, combined);
        write_reg(tlfr_pkg::REG_PULSE_CNT, pcount);
        write_reg(tlfr_pkg::REG_PULSE_HALF, phalf);
        write_reg(tlfr_pkg::REG_REARM, rearm);
        write_reg(tlfr_pkg::REG_SWEEP, sweep);
        write_reg(tlfr_pkg::REG_TURN_HOLD, hold);
        if ($urandom_range(2) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
        cfg_ch.valid <= 1'b0;
    endtask

    // Favor values that make flashes and sweeps visible within a few frames, with
    // zero, all ones and full-range values mixed in.
    function automatic logic [15:0] pick_setting(input int typical_max);
        int sel;

        sel = $urandom_range(9);
        case (sel)
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(typical_max, 1));
        endcase
    endfunction

    // Mostly well-formed driving: time moves forward in realistic steps and the lamp
    // inputs change now and then, so brake flashes, holds and sweeps play out. The
    // rest is noise: arbitrary timestamps and input patterns.
    task automatic run_segment(input int ticks);
        logic [TW-1:0] now;
        logic run, full, brake, turn, rev, fog;

        if ($urandom_range(3) == 0)
            now = 32'hFFFF_FFFF - 32'($urandom_range(3000));  // cross the wrap
        else
            now = $urandom;
        run   = 1'($urandom);
        full  = 1'($urandom);
        brake = 1'($urandom);
        turn  = 1'($urandom);
        rev   = 1'($urandom);
        fog   = 1'($urandom);
        for (int n = 0; n < ticks; n++) begin
            if ($urandom_range(99) < 12) begin
                send_tick($urandom, 1'($urandom), 1'($urandom), 1'($urandom),
                          1'($urandom), 1'($urandom), 1'($urandom));
            end else begin
                if ($urandom_range(9) == 0)
                    now = now + 32'($urandom_range(4000, 200));
                else
                    now = now + 32'($urandom_range(120, 1));
                if ($urandom_range(99) < 10) run   = ~run;
                if ($urandom_range(99) < 15) full  = ~full;
                if ($urandom_range(99) < 15) brake = ~brake;
                if ($urandom_range(99) < 20) turn  = ~turn;
                if ($urandom_range(99) < 10) rev   = ~rev;
                if ($urandom_range(99) < 10) fog   = ~fog;
                send_tick(now, run, full, brake, turn, rev, fog);
            end
        end
    endtask

    initial begin
        // Hold the sender side at a known value from time zero; the LED ready is set
        // at the first edge.
        rst_n               = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = tlfr_pkg::REG_COMBINED;
        cfg_ch.data         = '0;
        frame_ch.valid      = 1'b0;
        frame_ch.now_ms     = '0;
        frame_ch.run_on     = 1'b0;
        frame_ch.run_full   = 1'b0;
        frame_ch.brake_on   = 1'b0;
        frame_ch.turn_on    = 1'b0;
        frame_ch.reverse_on = 1'b0;
        frame_ch.fog_on     = 1'b0;
        sender_idle_pct     = 29;
        receiver_idle_pct   = 88;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Change re-arm and turn hold before the first frame: the times stored at
        // reset keep the old values, so a brake at 0 ms holds instead of flashing
        // and the turn zone starts out claimed.
        write_reg(tlfr_pkg::REG_REARM, 16'd1600);
        write_reg(tlfr_pkg::REG_TURN_HOLD, 16'd800);
        cfg_ch.valid <= 1'b0;

        //        now_ms        run   full  brake turn  rev   fog
        send_tick(32'd0,        1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd10,       1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // fresh application: flash full, dim, full, then settle into solid hold
        send_tick(32'd1700,     1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd1765,     1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd1830,     1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd2060,     1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        // quick re-application inside the re-arm window goes straight to hold
        send_tick(32'd2070,     1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd2100,     1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd2110,     1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        // amber sweep grows, clamps at the zone length, then the zone holds dark
        send_tick(32'd2200,     1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(32'd2350,     1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(32'd2600,     1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1);
        send_tick(32'd2700,     1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        send_tick(32'd3500,     1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1);
        // timestamp extremes and the wrap from all ones back to zero
        send_tick(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        send_tick(32'd0,        1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);

        // Combined mode, no flashes, longest half period, no re-arm, instant sweep,
        // longest hold. All-ones data checks that unused bits are dropped.
        wait_drained();
        program_all(16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF);
        send_tick(32'd100,      1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd110,      1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd120,      1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        send_tick(32'd130,      1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(32'd140,      1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);

        // Separate mode, most flashes with a zero half period, longest re-arm,
        // one-millisecond sweep so a long turn overflows 32 bits, zero hold.
        wait_drained();
        program_all(16'd0, 16'd15, 16'd0, 16'hFFFF, 16'd1, 16'd0);
        send_tick(32'd70000,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd70010,    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        send_tick(32'd70020,    1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(32'hF001_1184, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        send_tick(32'hF001_1185, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        // Random segments, each with its own settings. Draining before every write
        // also pauses the sender until the LED stream is empty.
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_drained();
            if (seg < 3) begin
                sender_idle_pct   = 29;
                receiver_idle_pct = 88;
            end else if (seg < 6) begin
                sender_idle_pct   = 88;
                receiver_idle_pct = 29;
            end else begin
                sender_idle_pct   = 0;
                receiver_idle_pct = 0;
            end
            program_all(16'($urandom), pick_setting(15), pick_setting(100),
                        pick_setting(400), pick_setting(600), pick_setting(900));
            run_segment(SEGMENT_TICKS);
        end

        wait_drained();
        if (fail_count == 0) begin
            $display("tail_light_frame_renderer_unit test passed");
        end else begin
            $display("tail_light_frame_renderer_unit test failed");
        end
        $finish;
    end

endmodule
